// ===== design/pscd_pkg.sv =====
// shared constants and types for the point to segment closest distance block
`default_nettype none
package pscd_pkg;
	localparam int FRAC_BITS = 16;
	localparam int QBITS = 41;
	localparam int DIV_SHIFT = QBITS - FRAC_BITS;
	localparam int ROOT_BITS = 32;
	localparam logic [QBITS-1:0] QCAP = {1'b0, 1'b1, {(QBITS-2){1'b0}}};
	localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

	localparam logic [1:0] REGION_LOW = 2'd0;
	localparam logic [1:0] REGION_MID = 2'd1;
	localparam logic [1:0] REGION_HIGH = 2'd2;

	typedef struct packed {
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic neg;
		logic degen;
	} div_side_t;

	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic [1:0] region;
		logic degen;
		logic sat;
		logic dovf;
	} sqrt_side_t;
endpackage
`default_nettype wire

// ===== design/pscd_div.sv =====
// pipelined restoring divider, one quotient bit per stage, capped quotient
`default_nettype none
module pscd_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic ce,
	input wire logic in_valid,
	input wire logic [63:0] in_mag,
	input wire logic [63:0] in_len2,
	input wire pscd_pkg::div_side_t in_side,
	output logic out_valid,
	output logic [pscd_pkg::QBITS-1:0] out_q,
	output pscd_pkg::div_side_t out_side
);
	localparam int QB = pscd_pkg::QBITS;
	localparam int SH = pscd_pkg::DIV_SHIFT;
	localparam int FB = pscd_pkg::FRAC_BITS;

	logic v_q [0:QB];
	logic ovf_q [0:QB];
	logic [63:0] rem_q [0:QB-1];
	logic [QB-1:0] bits_q [0:QB-1];
	logic [QB-1:0] quo_q [0:QB];
	pscd_pkg::div_side_t side_q [0:QB];
	logic out_valid_q;
	logic [QB-1:0] out_q_q;
	pscd_pkg::div_side_t out_side_q;

	// entry: overflow test and first partial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (ce) begin
			v_q[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			rem_q[0] <= in_mag >> SH;
			bits_q[0] <= {in_mag[SH-1:0], {FB{1'b0}}};
			quo_q[0] <= '0;
			ovf_q[0] <= {{SH{1'b0}}, in_mag} >= {in_len2, {SH{1'b0}}};
			side_q[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [63:0] tr;
		logic ge;
		assign tr = {rem_q[k-1][62:0], bits_q[k-1][QB-1]};
		assign ge = tr >= in_len2;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (ce) begin
				v_q[k] <= v_q[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				quo_q[k] <= {quo_q[k-1][QB-2:0], ge};
				ovf_q[k] <= ovf_q[k-1];
				side_q[k] <= side_q[k-1];
			end
		end
		if (k < QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce) begin
					rem_q[k] <= ge ? tr - in_len2 : tr;
					bits_q[k] <= bits_q[k-1] << 1;
				end
			end
		end
	end

	// cap stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ce) begin
			out_valid_q <= v_q[QB];
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			out_q_q <= (ovf_q[QB] || quo_q[QB] > pscd_pkg::QCAP) ? pscd_pkg::QCAP : quo_q[QB];
			out_side_q <= side_q[QB];
		end
	end

	assign out_valid = out_valid_q;
	assign out_q = out_q_q;
	assign out_side = out_side_q;
endmodule
`default_nettype wire

// ===== design/pscd_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none
module pscd_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic ce,
	input wire logic in_valid,
	input wire logic [63:0] in_x,
	input wire pscd_pkg::sqrt_side_t in_side,
	output logic out_valid,
	output logic [pscd_pkg::ROOT_BITS-1:0] out_root,
	output pscd_pkg::sqrt_side_t out_side
);
	localparam int RB = pscd_pkg::ROOT_BITS;

	logic v_q [1:RB];
	logic [RB+1:0] rem_q [1:RB-1];
	logic [2*RB-1:0] x_q [1:RB-1];
	logic [RB-1:0] root_q [1:RB];
	pscd_pkg::sqrt_side_t side_q [1:RB];

	for (genvar k = 1; k <= RB; k++) begin : g_step
		logic p_v;
		logic [RB+1:0] p_rem;
		logic [2*RB-1:0] p_x;
		logic [RB-1:0] p_root;
		pscd_pkg::sqrt_side_t p_side;
		logic [RB+2:0] cur;
		logic [RB+1:0] trial;
		logic ge;
		if (k == 1) begin : g_first
			assign p_v = in_valid;
			assign p_rem = '0;
			assign p_x = in_x;
			assign p_root = '0;
			assign p_side = in_side;
		end else begin : g_next
			assign p_v = v_q[k-1];
			assign p_rem = rem_q[k-1];
			assign p_x = x_q[k-1];
			assign p_root = root_q[k-1];
			assign p_side = side_q[k-1];
		end
		assign cur = {p_rem[RB:0], p_x[2*RB-1:2*RB-2]};
		assign trial = {p_root, 2'b01};
		assign ge = cur >= {1'b0, trial};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (ce) begin
				v_q[k] <= p_v;
			end
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				root_q[k] <= {p_root[RB-2:0], ge};
				side_q[k] <= p_side;
			end
		end
		if (k < RB) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce) begin
					rem_q[k] <= ge ? (RB+2)'(cur - {1'b0, trial}) : (RB+2)'(cur);
					x_q[k] <= p_x << 2;
				end
			end
		end
	end

	assign out_valid = v_q[RB];
	assign out_root = root_q[RB];
	assign out_side = side_q[RB];
endmodule
`default_nettype wire

// ===== design/point_segment_closest_distance_top.sv =====
// top level of the point to segment closest distance block
// usage:
// - configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the segment
//   registers: 0 start_x, 1 start_y, 2 dir_x, 3 dir_y, 4 t_low, 5 t_high; other indices
//   are dropped; cfg_ready is always high; write only while no point is in flight
// - slave stream takes one query point per beat, master stream gives one result per point
// - an input beat reaches m_tvalid for its result through three front stages, the 43 stage
//   divider (entry, 41 quotient bits, cap), six back stages, the 32 stage square root
//   pipeline and the output buffer
// - throughput is one point per cycle while the output buffer has room
// - the output sits in a two entry buffer; while the receiver stalls the pipeline keeps
//   moving until that buffer is full, then the whole pipeline holds and s_tready drops
// - reset clears all valid bits and the buffer and loads the default segment:
//   start at origin, direction 1.0 along x, parameter range 0.0 to 1.0
// - a zero direction gives the degenerate flag with every other field zero
`default_nettype none
module point_segment_closest_distance_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [63:0] s_tdata, // query_x, query_y
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [127:0] m_tdata, // param_t, near_x, near_y, distance
	output logic [3:0] m_tuser, // region, degenerate, saturated
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int FB = pscd_pkg::FRAC_BITS;
	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_DIR_X = 3'd2;
	localparam logic [2:0] REG_DIR_Y = 3'd3;
	localparam logic [2:0] REG_T_LOW = 3'd4;
	localparam logic [2:0] REG_T_HIGH = 3'd5;

	typedef struct packed {
		logic sat;
		logic degen;
		logic [1:0] region;
		logic [31:0] distance;
		logic [31:0] near_y;
		logic [31:0] near_x;
		logic [31:0] param_t;
	} res_t;

	// saturate to 32 bits signed, flag when clipped
	function automatic logic [32:0] sat32(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -64'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	// segment registers
	logic signed [31:0] start_x_q, start_y_q, dir_x_q, dir_y_q, t_low_q, t_high_q;
	logic [63:0] sqx_q, sqy_q, len2_q;
	logic [31:0] adx, ady;

	// global advance: the whole pipeline moves while the output buffer has room
	logic ce;
	logic [1:0] cnt_q;

	// front stages
	logic v_s1, v_s2, v_s3;
	logic signed [31:0] qx_s1, qy_s1, qx_s2, qy_s2, qx_s3, qy_s3;
	logic signed [32:0] dfx_s1, dfy_s1;
	logic signed [64:0] p1_s2, p2_s2;
	logic [63:0] mag_s3;
	logic neg_s3;
	logic [63:0] m1, m2, mag_c;
	logic neg_c;
	pscd_pkg::div_side_t div_in_side, div_out_side;
	logic div_valid;
	logic [pscd_pkg::QBITS-1:0] div_q;

	// back stages
	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [41:0] s_val;
	logic signed [31:0] t_c;
	logic [1:0] region_c;
	logic signed [31:0] qx_s4, qy_s4, qx_s5, qy_s5, qx_s6, qy_s6;
	logic signed [31:0] t_s4, t_s5, t_s6, t_s7, t_s8, t_s9;
	logic [1:0] rg_s4, rg_s5, rg_s6, rg_s7, rg_s8, rg_s9;
	logic dg_s4, dg_s5, dg_s6, dg_s7, dg_s8, dg_s9;
	logic signed [63:0] ptx_s5, pty_s5;
	logic [32:0] satx, saty;
	logic signed [31:0] nx_s6, ny_s6, nx_s7, ny_s7, nx_s8, ny_s8, nx_s9, ny_s9;
	logic sat_s6, sat_s7, sat_s8, sat_s9;
	logic signed [32:0] ex_c, ey_c;
	logic [32:0] ex_s7, ey_s7;
	logic [63:0] a_s8, b_s8;
	logic [64:0] sum_s9;
	pscd_pkg::sqrt_side_t sq_in_side, sq_out_side;
	logic sq_valid;
	logic [pscd_pkg::ROOT_BITS-1:0] sq_root;

	// output buffer
	res_t res_c;
	res_t buf_q [0:1];
	logic wr_q, rd_q;
	logic push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			dir_x_q <= pscd_pkg::ONE_Q;
			dir_y_q <= '0;
			t_low_q <= '0;
			t_high_q <= pscd_pkg::ONE_Q;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				REG_DIR_X: dir_x_q <= cfg_data;
				REG_DIR_Y: dir_y_q <= cfg_data;
				REG_T_LOW: t_low_q <= cfg_data;
				REG_T_HIGH: t_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// squared direction length, registered through the squares and then the sum
	assign adx = dir_x_q[31] ? 32'(-dir_x_q) : dir_x_q;
	assign ady = dir_y_q[31] ? 32'(-dir_y_q) : dir_y_q;
	always_ff @(posedge clk) begin
		sqx_q <= 64'(adx) * 64'(adx);
		sqy_q <= 64'(ady) * 64'(ady);
		len2_q <= sqx_q + sqy_q;
	end

	assign ce = (cnt_q != 2'd2);
	assign s_tready = ce;

	// valid bits of the top level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= div_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// s1: offset from the start, s2: products with the direction
	always_ff @(posedge clk) begin
		if (ce) begin
			qx_s1 <= s_tdata[31:0];
			qy_s1 <= s_tdata[63:32];
			dfx_s1 <= 33'(signed'(s_tdata[31:0])) - 33'(start_x_q);
			dfy_s1 <= 33'(signed'(s_tdata[63:32])) - 33'(start_y_q);
			qx_s2 <= qx_s1;
			qy_s2 <= qy_s1;
			p1_s2 <= 65'(dir_x_q) * 65'(dfx_s1);
			p2_s2 <= 65'(dir_y_q) * 65'(dfy_s1);
		end
	end

	// s3: signed dot product as sign and magnitude
	always_comb begin
		m1 = p1_s2[64] ? 64'(-p1_s2) : p1_s2[63:0];
		m2 = p2_s2[64] ? 64'(-p2_s2) : p2_s2[63:0];
		if (p1_s2[64] == p2_s2[64]) begin
			mag_c = m1 + m2;
			neg_c = p1_s2[64];
		end else if (m1 >= m2) begin
			mag_c = m1 - m2;
			neg_c = p1_s2[64];
		end else begin
			mag_c = m2 - m1;
			neg_c = p2_s2[64];
		end
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			qx_s3 <= qx_s2;
			qy_s3 <= qy_s2;
			mag_s3 <= mag_c;
			neg_s3 <= neg_c;
		end
	end

	assign div_in_side.qx = qx_s3;
	assign div_in_side.qy = qy_s3;
	assign div_in_side.neg = neg_s3;
	assign div_in_side.degen = (dir_x_q == '0) && (dir_y_q == '0);

	pscd_div u_div (
		.clk (clk),
		.arst_n (arst_n),
		.ce (ce),
		.in_valid (v_s3),
		.in_mag (mag_s3),
		.in_len2 (len2_q),
		.in_side (div_in_side),
		.out_valid (div_valid),
		.out_q (div_q),
		.out_side (div_out_side)
	);

	// s4: signed projection and clamp to the parameter range
	always_comb begin
		s_val = {1'b0, div_q};
		if (div_out_side.neg) begin
			s_val = -s_val;
		end
		if (s_val <= 42'(t_low_q)) begin
			t_c = t_low_q;
			region_c = pscd_pkg::REGION_LOW;
		end else if (s_val <= 42'(t_high_q)) begin
			t_c = s_val[31:0];
			region_c = pscd_pkg::REGION_MID;
		end else begin
			t_c = t_high_q;
			region_c = pscd_pkg::REGION_HIGH;
		end
	end

	// s5: scaled direction, s6: closest point with saturation
	assign satx = sat32(64'(start_x_q) + (ptx_s5 >>> FB));
	assign saty = sat32(64'(start_y_q) + (pty_s5 >>> FB));
	// s7: distance components as magnitudes
	assign ex_c = 33'(qx_s6) - 33'(nx_s6);
	assign ey_c = 33'(qy_s6) - 33'(ny_s6);

	always_ff @(posedge clk) begin
		if (ce) begin
			qx_s4 <= div_out_side.qx;
			qy_s4 <= div_out_side.qy;
			dg_s4 <= div_out_side.degen;
			t_s4 <= t_c;
			rg_s4 <= region_c;

			qx_s5 <= qx_s4;
			qy_s5 <= qy_s4;
			dg_s5 <= dg_s4;
			t_s5 <= t_s4;
			rg_s5 <= rg_s4;
			ptx_s5 <= 64'(t_s4) * 64'(dir_x_q);
			pty_s5 <= 64'(t_s4) * 64'(dir_y_q);

			qx_s6 <= qx_s5;
			qy_s6 <= qy_s5;
			dg_s6 <= dg_s5;
			t_s6 <= t_s5;
			rg_s6 <= rg_s5;
			nx_s6 <= satx[31:0];
			ny_s6 <= saty[31:0];
			sat_s6 <= satx[32] | saty[32];

			dg_s7 <= dg_s6;
			t_s7 <= t_s6;
			rg_s7 <= rg_s6;
			nx_s7 <= nx_s6;
			ny_s7 <= ny_s6;
			sat_s7 <= sat_s6;
			ex_s7 <= ex_c[32] ? 33'(-ex_c) : ex_c;
			ey_s7 <= ey_c[32] ? 33'(-ey_c) : ey_c;

			// s8: squares
			dg_s8 <= dg_s7;
			t_s8 <= t_s7;
			rg_s8 <= rg_s7;
			nx_s8 <= nx_s7;
			ny_s8 <= ny_s7;
			sat_s8 <= sat_s7;
			a_s8 <= 64'(66'(ex_s7) * 66'(ex_s7));
			b_s8 <= 64'(66'(ey_s7) * 66'(ey_s7));

			// s9: sum, carry out means the distance saturates
			dg_s9 <= dg_s8;
			t_s9 <= t_s8;
			rg_s9 <= rg_s8;
			nx_s9 <= nx_s8;
			ny_s9 <= ny_s8;
			sat_s9 <= sat_s8;
			sum_s9 <= 65'(a_s8) + 65'(b_s8);
		end
	end

	assign sq_in_side.t = t_s9;
	assign sq_in_side.nx = nx_s9;
	assign sq_in_side.ny = ny_s9;
	assign sq_in_side.region = rg_s9;
	assign sq_in_side.degen = dg_s9;
	assign sq_in_side.sat = sat_s9;
	assign sq_in_side.dovf = sum_s9[64];

	pscd_sqrt u_sqrt (
		.clk (clk),
		.arst_n (arst_n),
		.ce (ce),
		.in_valid (v_s9),
		.in_x (sum_s9[63:0]),
		.in_side (sq_in_side),
		.out_valid (sq_valid),
		.out_root (sq_root),
		.out_side (sq_out_side)
	);

	// result assembly; degenerate direction forces everything but the flag to zero
	always_comb begin
		res_c = '0;
		res_c.degen = sq_out_side.degen;
		if (!sq_out_side.degen) begin
			res_c.param_t = sq_out_side.t;
			res_c.near_x = sq_out_side.nx;
			res_c.near_y = sq_out_side.ny;
			res_c.distance = sq_out_side.dovf ? 32'hFFFF_FFFF : sq_root;
			res_c.region = sq_out_side.region;
			res_c.sat = sq_out_side.sat | sq_out_side.dovf;
		end
	end

	// two entry output buffer
	assign push = ce && sq_valid;
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			wr_q <= wr_q ^ push;
			rd_q <= rd_q ^ pop;
		end
	end
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res_c;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata = {buf_q[rd_q].distance, buf_q[rd_q].near_y,
		buf_q[rd_q].near_x, buf_q[rd_q].param_t};
	assign m_tuser = {buf_q[rd_q].sat, buf_q[rd_q].degen, buf_q[rd_q].region};

	// degenerate beats carry nothing but the flag
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tdata == '0 && m_tuser[1:0] == pscd_pkg::REGION_LOW
		&& !m_tuser[3]))
		else $error("degenerate result with nonzero fields");

	// interior parameter lies inside the configured range
	a_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[2] && m_tuser[1:0] == pscd_pkg::REGION_MID) |->
		($signed(m_tdata[31:0]) > t_low_q && $signed(m_tdata[31:0]) <= t_high_q))
		else $error("interior parameter outside range");

	// buffer never overflows: a push into a full buffer cannot happen
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2 && $stable(rd_q)))
		else $error("output buffer overrun");
endmodule
`default_nettype wire
